### design/qbrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbrf_pkg: shared definitions for the quartic bisection root finder
// Widths, register indexes, stop codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package qbrf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int XW         = 32;                 // bracket / coefficient width
  localparam int PROD_W     = DATA_WIDTH + XW;    // exact Horner product
  localparam int SUM_W      = ((DATA_WIDTH > XW) ? DATA_WIDTH : XW) + 1;
  localparam int TOL_W      = 31;
  localparam int CNT_W      = 6;
  localparam int IDX_W      = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_COEF_X4    = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_X3    = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_X2    = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_X1    = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_X0    = 3'd4;
  localparam logic [IDX_W-1:0] REG_WIDTH_TOL  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

  localparam logic [TOL_W-1:0] WIDTH_TOL_RST  = 31'd1;
  localparam logic [CNT_W-1:0] ITER_LIMIT_RST = 6'd32;

  typedef enum logic [1:0] {
    CAUSE_ZERO  = 2'd0,
    CAUSE_WIDTH = 2'd1,
    CAUSE_LIMIT = 2'd2
  } stop_cause_e;

  typedef struct packed {
    logic signed [XW-1:0] coef_x4;
    logic signed [XW-1:0] coef_x3;
    logic signed [XW-1:0] coef_x2;
    logic signed [XW-1:0] coef_x1;
    logic signed [XW-1:0] coef_x0;
    logic [TOL_W-1:0]     width_tol;
    logic [CNT_W-1:0]     iter_limit;
  } cfg_t;

  typedef struct packed {
    logic        load;       // take a new bracket
    logic        init_lo;    // start evaluation at the lower end
    logic        init_mid;   // form midpoint, start evaluation there
    logic        mul;        // acc * x into product register
    logic        add;        // scale, saturate, add coefficient
    logic [1:0]  coef_sel;   // 0..3 selects x3..x0
    logic        save_flo;   // keep sign of p(lower)
    logic        update;     // move one bracket end to the midpoint
    logic        finish;     // latch result, strobe next cycle
    stop_cause_e cause;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic width_ok;
    logic limit_hit;
  } dp_status_t;

endpackage

### design/qbrf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbrf_ctrl: bisection sequencer
// Steps the shared Horner datapath through p(lower) once, then one midpoint
// evaluation and decision per pass.
// ----------------------------------------------------------------------------
module qbrf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  qbrf_pkg::dp_status_t status_i,
  output qbrf_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INIT   = 6'b000010,
    S_MUL    = 6'b000100,
    S_ADD    = 6'b001000,
    S_MID    = 6'b010000,
    S_DECIDE = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       phase_mid_q, phase_mid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    phase_mid_d = phase_mid_q;
    cmd_o       = '0;
    cmd_o.cause = qbrf_pkg::CAUSE_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init_lo = 1'b1;
        step_d        = 2'd0;
        phase_mid_d   = 1'b0;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add      = 1'b1;
        cmd_o.coef_sel = step_q;
        step_d         = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = phase_mid_q ? S_DECIDE : S_MID;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MID: begin
        // acc still holds p(lower) on the first entry
        cmd_o.save_flo = !phase_mid_q;
        cmd_o.init_mid = 1'b1;
        phase_mid_d    = 1'b1;
        step_d         = 2'd0;
        state_d        = S_MUL;
      end
      S_DECIDE: begin
        priority if (status_i.acc_zero) begin
          cmd_o.finish = 1'b1;
          cmd_o.cause  = qbrf_pkg::CAUSE_ZERO;
          state_d      = S_IDLE;
        end else if (status_i.width_ok) begin
          cmd_o.finish = 1'b1;
          cmd_o.cause  = qbrf_pkg::CAUSE_WIDTH;
          state_d      = S_IDLE;
        end else if (status_i.limit_hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.cause  = qbrf_pkg::CAUSE_LIMIT;
          state_d      = S_IDLE;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = S_MID;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 2'd0;
      phase_mid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_mid_q <= phase_mid_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

### design/qbrf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbrf_dp: bracket registers and shared Horner evaluator
// One signed multiplier, a scale/saturate/add stage, bracket update and the
// result registers.
// ----------------------------------------------------------------------------
module qbrf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qbrf_pkg::cfg_t                      cfg_i,
  input  qbrf_pkg::dp_cmd_t                   cmd_i,
  output qbrf_pkg::dp_status_t                status_o,
  input  logic signed [qbrf_pkg::XW-1:0]      lower_bound_i,
  input  logic signed [qbrf_pkg::XW-1:0]      upper_bound_i,
  output logic                                done_o,
  output logic signed [qbrf_pkg::XW-1:0]      root_estimate_o,
  output logic [1:0]                          stop_cause_o,
  output logic [qbrf_pkg::CNT_W-1:0]          passes_used_o
);

  localparam int DW = qbrf_pkg::DATA_WIDTH;
  localparam int PW = qbrf_pkg::PROD_W;
  localparam int SW = qbrf_pkg::SUM_W;
  localparam int XW = qbrf_pkg::XW;
  localparam int FB = qbrf_pkg::FRAC_BITS;

  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_prod(input logic signed [PW-1:0] v);
    logic [PW-DW:0] top;
    top = v[PW-1:DW-1];
    if ((top == '0) || (top == '1)) begin
      sat_prod = v[DW-1:0];
    end else begin
      sat_prod = v[PW-1] ? DMIN : DMAX;
    end
  endfunction

  function automatic logic signed [DW-1:0] sat_sum(input logic signed [SW-1:0] v);
    logic [SW-DW:0] top;
    top = v[SW-1:DW-1];
    if ((top == '0) || (top == '1)) begin
      sat_sum = v[DW-1:0];
    end else begin
      sat_sum = v[SW-1] ? DMIN : DMAX;
    end
  endfunction

  logic signed [XW-1:0] lo_q, hi_q, mid_q, x_q;
  logic signed [DW-1:0] acc_q;
  logic signed [PW-1:0] prod_q;
  logic                 width_ok_q;
  logic                 flo_zero_q, flo_neg_q;
  logic [qbrf_pkg::CNT_W-1:0] passes_q;
  logic                 done_q;
  logic signed [XW-1:0] root_q;
  logic [1:0]           cause_q;
  logic [qbrf_pkg::CNT_W-1:0] passes_out_q;

  // midpoint: floor((lo + hi) / 2) at full precision
  logic signed [XW:0]   sum_c;
  logic signed [XW-1:0] mid_c;
  assign sum_c = {lo_q[XW-1], lo_q} + {hi_q[XW-1], hi_q};
  assign mid_c = sum_c[XW:1];

  // bracket width |hi - lo|
  logic signed [XW:0] diff_a, diff_b;
  logic [XW:0]        width_c;
  assign diff_a  = {hi_q[XW-1], hi_q} - {lo_q[XW-1], lo_q};
  assign diff_b  = {lo_q[XW-1], lo_q} - {hi_q[XW-1], hi_q};
  assign width_c = diff_a[XW] ? diff_b : diff_a;

  // leading coefficient saturated to the accumulator range
  logic signed [DW-1:0] c4_sat;
  assign c4_sat = sat_sum({{(SW-XW){cfg_i.coef_x4[XW-1]}}, cfg_i.coef_x4});

  // Horner step: product / 2^FB toward zero, saturate, add coefficient, saturate
  logic signed [XW-1:0] coef_c;
  logic signed [PW-1:0] shr_c, trunc_c;
  logic                 adj_c;
  logic signed [DW-1:0] term_c, acc_next_c;
  logic signed [SW-1:0] add_c;

  always_comb begin
    unique case (cmd_i.coef_sel)
      2'd0:    coef_c = cfg_i.coef_x3;
      2'd1:    coef_c = cfg_i.coef_x2;
      2'd2:    coef_c = cfg_i.coef_x1;
      default: coef_c = cfg_i.coef_x0;
    endcase
  end

  assign shr_c      = prod_q >>> FB;
  assign adj_c      = prod_q[PW-1] && (prod_q[FB-1:0] != '0);
  assign trunc_c    = shr_c + {{(PW-1){1'b0}}, adj_c};
  assign term_c     = sat_prod(trunc_c);
  assign add_c      = {{(SW-DW){term_c[DW-1]}}, term_c} + {{(SW-XW){coef_c[XW-1]}}, coef_c};
  assign acc_next_c = sat_sum(add_c);

  // same strict sign as p(lower): move the lower end
  logic move_lo_c;
  assign move_lo_c = (acc_q != '0) && !flo_zero_q && (acc_q[DW-1] == flo_neg_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q <= lower_bound_i;
      hi_q <= upper_bound_i;
    end else if (cmd_i.update) begin
      if (move_lo_c) begin
        lo_q <= mid_q;
      end else begin
        hi_q <= mid_q;
      end
    end
    if (cmd_i.init_lo) begin
      x_q   <= lo_q;
      acc_q <= c4_sat;
    end else if (cmd_i.init_mid) begin
      x_q   <= mid_c;
      acc_q <= c4_sat;
    end else if (cmd_i.add) begin
      acc_q <= acc_next_c;
    end
    if (cmd_i.init_mid) begin
      mid_q      <= mid_c;
      width_ok_q <= (width_c <= {2'b00, cfg_i.width_tol});
    end
    if (cmd_i.mul) begin
      prod_q <= acc_q * x_q;
    end
    if (cmd_i.save_flo) begin
      flo_zero_q <= (acc_q == '0);
      flo_neg_q  <= acc_q[DW-1];
    end
    if (cmd_i.finish) begin
      root_q       <= mid_q;
      cause_q      <= cmd_i.cause;
      passes_out_q <= passes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      passes_q <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        passes_q <= '0;
      end else if (cmd_i.update) begin
        passes_q <= passes_q + 1'b1;
      end
      done_q <= cmd_i.finish;
    end
  end

  assign status_o.acc_zero  = (acc_q == '0);
  assign status_o.width_ok  = width_ok_q;
  assign status_o.limit_hit = (passes_q >= cfg_i.iter_limit);

  assign done_o          = done_q;
  assign root_estimate_o = root_q;
  assign stop_cause_o    = cause_q;
  assign passes_used_o   = passes_out_q;

endmodule

### design/quartic_bisection_root_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartic_bisection_root_finder: bisection root search on a quartic
// Holds the configuration registers and joins the sequencer to the datapath.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  request   | start high, busy low   | lower_bound_i, upper_bound_i
//  result    | done_o, one cycle      | root_estimate_o, stop_cause_o,
//            |                        | passes_used_o
//  config    | cfg_we_i, no wait      | cfg_idx_i, cfg_wdata_i
//
//  One request at a time. p(lower) is evaluated once, then each pass takes
//  a midpoint, four Horner steps on the one shared multiplier, and a
//  decision. The result strobes after the last decision; busy falls with it.
//  Reset clears the sequencer and loads the register reset values.
//  The result cannot be held off; it is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module quartic_bisection_root_finder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qbrf_pkg::XW-1:0]     lower_bound_i,
  input  logic signed [qbrf_pkg::XW-1:0]     upper_bound_i,
  output logic                               done_o,
  output logic signed [qbrf_pkg::XW-1:0]     root_estimate_o,
  output logic [1:0]                         stop_cause_o,
  output logic [qbrf_pkg::CNT_W-1:0]         passes_used_o,
  input  logic                               cfg_we_i,
  input  logic [qbrf_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [qbrf_pkg::XW-1:0]            cfg_wdata_i
);

  qbrf_pkg::cfg_t       cfg_q;
  qbrf_pkg::dp_cmd_t    cmd;
  qbrf_pkg::dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_x4    <= '0;
      cfg_q.coef_x3    <= '0;
      cfg_q.coef_x2    <= '0;
      cfg_q.coef_x1    <= '0;
      cfg_q.coef_x0    <= '0;
      cfg_q.width_tol  <= qbrf_pkg::WIDTH_TOL_RST;
      cfg_q.iter_limit <= qbrf_pkg::ITER_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qbrf_pkg::REG_COEF_X4:    cfg_q.coef_x4    <= cfg_wdata_i;
        qbrf_pkg::REG_COEF_X3:    cfg_q.coef_x3    <= cfg_wdata_i;
        qbrf_pkg::REG_COEF_X2:    cfg_q.coef_x2    <= cfg_wdata_i;
        qbrf_pkg::REG_COEF_X1:    cfg_q.coef_x1    <= cfg_wdata_i;
        qbrf_pkg::REG_COEF_X0:    cfg_q.coef_x0    <= cfg_wdata_i;
        qbrf_pkg::REG_WIDTH_TOL:  cfg_q.width_tol  <= cfg_wdata_i[qbrf_pkg::TOL_W-1:0];
        qbrf_pkg::REG_ITER_LIMIT: cfg_q.iter_limit <= cfg_wdata_i[qbrf_pkg::CNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  qbrf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  qbrf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .lower_bound_i   (lower_bound_i),
    .upper_bound_i   (upper_bound_i),
    .done_o          (done_o),
    .root_estimate_o (root_estimate_o),
    .stop_cause_o    (stop_cause_o),
    .passes_used_o   (passes_used_o)
  );

endmodule

### tb/sv/qbrf_root_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbrf_root_checker: result checker for the quartic bisection root finder
// Follows the register writes, predicts root, stop cause and pass count for
// every accepted request, and compares each result strobe in request order.
// ----------------------------------------------------------------------------
module qbrf_root_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic signed [qbrf_pkg::XW-1:0] lower_bound_i,
  input  logic signed [qbrf_pkg::XW-1:0] upper_bound_i,
  input  logic                           done_i,
  input  logic signed [qbrf_pkg::XW-1:0] root_estimate_i,
  input  logic [1:0]                     stop_cause_i,
  input  logic [qbrf_pkg::CNT_W-1:0]     passes_used_i,
  input  logic                           cfg_we_i,
  input  logic [qbrf_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [qbrf_pkg::XW-1:0]        cfg_wdata_i,
  output int                             roots_pending_o,
  output int                             root_errors_o
);
  import qbrf_pkg::*;

  localparam longint DW_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint DW_MIN = -DW_MAX - 1;
  localparam longint FX_ONE = longint'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic signed [XW-1:0] root;
    stop_cause_e          cause;
    logic [CNT_W-1:0]     passes;
  } root_t;

  // coef_q[0] is the x^4 term, coef_q[4] the constant
  logic signed [XW-1:0] coef_q [0:4];
  logic [TOL_W-1:0]     tol_q;
  logic [CNT_W-1:0]     limit_q;
  root_t                expected_roots [$];

  function automatic longint clamp_dw(longint v);
    if (v > DW_MAX) return DW_MAX;
    if (v < DW_MIN) return DW_MIN;
    return v;
  endfunction

  // Horner; products truncate toward zero, every step saturates
  function automatic longint eval_quartic(longint x);
    longint acc;
    acc = clamp_dw(longint'(coef_q[0]));
    for (int k = 1; k < 5; k++)
      acc = clamp_dw(clamp_dw((acc * x) / FX_ONE) + longint'(coef_q[k]));
    return acc;
  endfunction

  function automatic root_t bisect_root(logic signed [XW-1:0] lower,
                                        logic signed [XW-1:0] upper);
    longint           lo;
    longint           hi;
    longint           mid;
    longint           f_mid;
    longint           f_lo;
    longint           span;
    logic [CNT_W-1:0] passes;
    logic             stop;
    root_t            res;
    lo        = longint'(lower);
    hi        = longint'(upper);
    mid       = 0;
    passes    = '0;
    stop      = 1'b0;
    res.cause = CAUSE_ZERO;
    while (!stop) begin
      mid   = (lo + hi) >>> 1;  // floor of the mean
      f_mid = eval_quartic(mid);
      span  = (hi > lo) ? hi - lo : lo - hi;
      if (f_mid == 0) begin
        res.cause = CAUSE_ZERO;
        stop      = 1'b1;
      end else if (span <= longint'(tol_q)) begin
        res.cause = CAUSE_WIDTH;
        stop      = 1'b1;
      end else if (passes >= limit_q) begin
        res.cause = CAUSE_LIMIT;
        stop      = 1'b1;
      end else begin
        // a zero at the lower end never counts as the same sign
        f_lo = eval_quartic(lo);
        if ((f_mid > 0 && f_lo > 0) || (f_mid < 0 && f_lo < 0)) lo = mid;
        else hi = mid;
        passes++;
      end
    end
    res.root   = mid[XW-1:0];
    res.passes = passes;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    root_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) coef_q[k] = '0;
      tol_q   = WIDTH_TOL_RST;
      limit_q = ITER_LIMIT_RST;
      expected_roots.delete();
    end else begin
      if (done_i) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected result: root %0d cause %0d passes %0d",
                   $time, root_estimate_i, stop_cause_i, passes_used_i);
          root_errors_o++;
        end else begin
          want = expected_roots.pop_front();
          if (root_estimate_i !== want.root) begin
            $display("%0t: root_estimate expected %0d, actual %0d",
                     $time, want.root, root_estimate_i);
            root_errors_o++;
          end
          if (stop_cause_i !== want.cause) begin
            $display("%0t: stop_cause expected %0d, actual %0d",
                     $time, want.cause, stop_cause_i);
            root_errors_o++;
          end
          if (passes_used_i !== want.passes) begin
            $display("%0t: passes_used expected %0d, actual %0d",
                     $time, want.passes, passes_used_i);
            root_errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COEF_X4, REG_COEF_X3, REG_COEF_X2, REG_COEF_X1, REG_COEF_X0:
            coef_q[cfg_idx_i] = cfg_wdata_i;
          REG_WIDTH_TOL:  tol_q = cfg_wdata_i[TOL_W-1:0];
          REG_ITER_LIMIT: limit_q = cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        expected_roots.push_back(bisect_root(lower_bound_i, upper_bound_i));
    end
    roots_pending_o = expected_roots.size();
  end

endmodule

### tb/sv/tb_quartic_bisection_root_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quartic_bisection_root_finder: top-level bench for the root finder
// Directed brackets on hand-picked polynomials, then random coefficient sets,
// tolerances and limits with random brackets and random request gaps.
// ----------------------------------------------------------------------------
module tb_quartic_bisection_root_finder;
  import qbrf_pkg::*;

  localparam logic [IDX_W-1:0]     REG_UNUSED   = 3'd7;
  localparam logic signed [XW-1:0] Q_ONE        = 32'sh0001_0000;
  localparam logic signed [XW-1:0] X_MIN        = 32'sh8000_0000;
  localparam logic signed [XW-1:0] X_MAX        = 32'sh7FFF_FFFF;
  localparam int                   RANDOM_ITEMS = 1100;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic signed [XW-1:0] lower_bound_i;
  logic signed [XW-1:0] upper_bound_i;
  logic                 done_o;
  logic signed [XW-1:0] root_estimate_o;
  logic [1:0]           stop_cause_o;
  logic [CNT_W-1:0]     passes_used_o;
  logic                 cfg_we_i;
  logic [IDX_W-1:0]     cfg_idx_i;
  logic [XW-1:0]        cfg_wdata_i;
  int                   roots_pending;
  int                   root_errors;

  quartic_bisection_root_finder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .lower_bound_i   (lower_bound_i),
    .upper_bound_i   (upper_bound_i),
    .done_o          (done_o),
    .root_estimate_o (root_estimate_o),
    .stop_cause_o    (stop_cause_o),
    .passes_used_o   (passes_used_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  qbrf_root_checker root_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .lower_bound_i   (lower_bound_i),
    .upper_bound_i   (upper_bound_i),
    .done_i          (done_o),
    .root_estimate_i (root_estimate_o),
    .stop_cause_i    (stop_cause_o),
    .passes_used_i   (passes_used_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .roots_pending_o (roots_pending),
    .root_errors_o   (root_errors)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  // uniform in +/- span in Q16.16
  function automatic logic signed [XW-1:0] rand_fixed(int span);
    int v;
    v = int'($urandom_range(0, 2 * span * (1 << FRAC_BITS))) - span * (1 << FRAC_BITS);
    return v;
  endfunction

  function automatic logic signed [XW-1:0] rand_extreme();
    case ($urandom_range(0, 5))
      0:       return X_MIN;
      1:       return X_MAX;
      2:       return '0;
      3:       return Q_ONE;
      4:       return -Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [XW-1:0] make_coef(int mode);
    if (mode <= 5) return ($urandom_range(0, 3) == 0) ? '0 : rand_fixed(4);
    if (mode <= 7) return $urandom;
    return rand_extreme();
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [XW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  task automatic load_poly(input logic signed [XW-1:0] c4, c3, c2, c1, c0,
                           input logic [XW-1:0] tol_data, lim_data);
    write_reg(REG_COEF_X4, c4);
    write_reg(REG_COEF_X3, c3);
    write_reg(REG_COEF_X2, c2);
    write_reg(REG_COEF_X1, c1);
    write_reg(REG_COEF_X0, c0);
    write_reg(REG_WIDTH_TOL, tol_data);
    write_reg(REG_ITER_LIMIT, lim_data);
    cfg_we_i <= 1'b0;
  endtask

  // start stays high after the accept unless a gap follows
  task automatic send_bracket(input logic signed [XW-1:0] lo, hi, input int gap);
    start         <= 1'b1;
    lower_bound_i <= lo;
    upper_bound_i <= hi;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (roots_pending != 0 || busy) @(negedge clk_i);
  endtask

  initial begin
    int                   sent;
    int                   burst;
    int                   coef_mode;
    int                   kind;
    int                   r;
    logic                 steady;
    logic [TOL_W-1:0]     tol;
    logic [CNT_W-1:0]     lim;
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    lower_bound_i = '0;
    upper_bound_i = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: all coefficients zero, every midpoint is a root
    send_bracket('0, '0, pick_gap());
    send_bracket(X_MIN, X_MAX, pick_gap());
    drain();

    // x^2 - 2: normal, reversed, no sign change, full range, tiny bracket
    load_poly('0, '0, Q_ONE, '0, -32'sh0002_0000, 32'd1, 32'd32);
    send_bracket('0, 2 * Q_ONE, pick_gap());
    send_bracket(2 * Q_ONE, '0, pick_gap());
    send_bracket(3 * Q_ONE, 7 * Q_ONE, pick_gap());
    send_bracket(X_MIN, X_MAX, pick_gap());
    send_bracket(X_MAX, X_MIN, pick_gap());
    send_bracket(32'sd5, 32'sd5, pick_gap());
    send_bracket(X_MIN, X_MIN, pick_gap());
    drain();

    // x - 1, zero tolerance: root at an end and exactly at a midpoint
    load_poly('0, '0, '0, Q_ONE, -Q_ONE, 32'd0, 32'd48);
    send_bracket(Q_ONE, 5 * Q_ONE, pick_gap());
    send_bracket('0, 2 * Q_ONE, pick_gap());
    send_bracket(-3 * Q_ONE, Q_ONE, pick_gap());
    drain();

    // saturating coefficients, widest tolerance, limit written as zero
    load_poly(X_MAX, X_MAX, X_MIN, X_MAX, X_MIN, 32'hFFFF_FFFF, 32'h0000_0040);
    send_bracket(X_MIN, X_MAX, pick_gap());
    send_bracket(X_MAX, X_MAX, pick_gap());
    send_bracket(-Q_ONE, Q_ONE, pick_gap());
    drain();

    // x^3 - x, limit 63, tolerance 0 (upper data bits must be dropped)
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    load_poly('0, Q_ONE, '0, -Q_ONE, '0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_bracket(-3 * Q_ONE, 4 * Q_ONE, pick_gap());
    send_bracket(X_MIN, X_MAX, pick_gap());
    send_bracket(X_MAX, X_MIN, pick_gap());

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
      coef_mode = $urandom_range(0, 9);
      r = $urandom_range(0, 9);
      if (r <= 5)      tol = TOL_W'($urandom_range(0, 255));
      else if (r <= 7) tol = TOL_W'($urandom);
      else if (r == 8) tol = '0;
      else             tol = '1;
      r = $urandom_range(0, 9);
      if (r <= 6)      lim = CNT_W'($urandom_range(1, 32));
      else if (r == 7) lim = '0;
      else if (r == 8) lim = CNT_W'($urandom_range(33, 62));
      else             lim = '1;
      load_poly(make_coef(coef_mode), make_coef(coef_mode), make_coef(coef_mode),
                make_coef(coef_mode), make_coef(coef_mode),
                {1'($urandom), tol}, {26'($urandom), lim});
      steady = ($urandom_range(0, 4) == 0);
      burst  = $urandom_range(15, 50);
      for (int n = 0; n < burst; n++) begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          lo = rand_fixed(8);
          hi = rand_fixed(8);
        end else if (kind == 7) begin
          lo = $urandom;
          hi = $urandom;
        end else if (kind == 8) begin
          lo = rand_fixed(8);
          hi = lo + $urandom_range(0, 3);
        end else begin
          lo = rand_extreme();
          hi = rand_extreme();
        end
        send_bracket(lo, hi, steady ? 0 : pick_gap());
      end
      sent += burst;
    end

    drain();
    repeat (50) @(negedge clk_i);
    if (root_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
